// File: hw/rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and the control store of the hash table sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  // table geometry
  localparam int unsigned TABLE_SIZE = 1021;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned REM_W      = IDX_W + 1;

  // field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PROBE_W  = 10;
  localparam int unsigned ENTRY_W  = 1 + KEY_W + VAL_W;
  localparam int unsigned PROD_W   = KEY_W + 32;

  localparam logic [PROBE_W-1:0] PROBES_MAX = '1;

  // double hashing step base
  localparam int unsigned DH_PRIME = 17;
  localparam int unsigned STEP_W   = $clog2(DH_PRIME);

  // reciprocals for remainder by multiplication, quotient low by at most one
  localparam int unsigned TAB_SHIFT = KEY_W + IDX_W;
  localparam int unsigned DH_SHIFT  = KEY_W + STEP_W;
  localparam logic [31:0] TAB_RECIP = 32'((64'd1 << TAB_SHIFT) / 64'(TABLE_SIZE));
  localparam logic [31:0] DH_RECIP  = 32'((64'd1 << DH_SHIFT) / 64'(DH_PRIME));

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_DOUBLE = 1'b1
  } mode_e;

  typedef struct packed {
    func_e            func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [PROBE_W-1:0] probes;
  } out_t;

  // divisor of the shared remainder unit
  typedef enum logic {
    DIV_TABLE = 1'b0,
    DIV_DH    = 1'b1
  } div_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN_FIRE   = 3'd1,
    C_CLR_LAST  = 3'd2,
    C_PROBE_END = 3'd3,
    C_OUT_FREE  = 3'd4
  } cond_e;

  // microprogram steps
  typedef enum logic [3:0] {
    PC_CLR   = 4'd0,
    PC_IDLE  = 4'd1,
    PC_MULH  = 4'd2,
    PC_REMH  = 4'd3,
    PC_HOME  = 4'd4,
    PC_REMS  = 4'd5,
    PC_STEP  = 4'd6,
    PC_EVAL  = 4'd7,
    PC_DONE  = 4'd8
  } pc_e;

  typedef struct packed {
    logic  in_rdy;
    logic  clr_wr;
    logic  mul_en;
    div_e  mul_sel;
    logic  rem_en;
    div_e  rem_sel;
    logic  set_home;
    logic  set_step;
    logic  rd_home;
    logic  eval;
    logic  out_load;
    cond_e cond;
    pc_e   target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic clr_last;
    logic probe_end;
    logic out_free;
  } flags_t;

  // control store: one word per step, jump to target when cond holds, else hold
  function automatic ctl_t rom(input pc_e pc);
    ctl_t c;
    c = '{in_rdy: 1'b0, clr_wr: 1'b0, mul_en: 1'b0, mul_sel: DIV_TABLE,
          rem_en: 1'b0, rem_sel: DIV_TABLE, set_home: 1'b0, set_step: 1'b0,
          rd_home: 1'b0, eval: 1'b0, out_load: 1'b0, cond: C_ALWAYS,
          target: PC_IDLE};
    case (pc)
      PC_CLR: begin
        c.clr_wr = 1'b1;
        c.cond   = C_CLR_LAST;
        c.target = PC_IDLE;
      end
      PC_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = C_IN_FIRE;
        c.target = PC_MULH;
      end
      PC_MULH: begin
        c.mul_en  = 1'b1;
        c.mul_sel = DIV_TABLE;
        c.target  = PC_REMH;
      end
      PC_REMH: begin
        c.rem_en  = 1'b1;
        c.rem_sel = DIV_TABLE;
        c.target  = PC_HOME;
      end
      PC_HOME: begin
        c.rem_sel  = DIV_TABLE;
        c.set_home = 1'b1;
        c.mul_en   = 1'b1;
        c.mul_sel  = DIV_DH;
        c.target   = PC_REMS;
      end
      PC_REMS: begin
        c.rem_en  = 1'b1;
        c.rem_sel = DIV_DH;
        c.target  = PC_STEP;
      end
      PC_STEP: begin
        c.rem_sel  = DIV_DH;
        c.set_step = 1'b1;
        c.rd_home  = 1'b1;
        c.target   = PC_EVAL;
      end
      PC_EVAL: begin
        c.eval   = 1'b1;
        c.cond   = C_PROBE_END;
        c.target = PC_DONE;
      end
      PC_DONE: begin
        c.out_load = 1'b1;
        c.cond     = C_OUT_FREE;
        c.target   = PC_IDLE;
      end
      default: begin
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/oaht_useq.sv
// ----------------------------------------------------------------------------
// oaht_useq
// Microprogram sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire oaht_pkg::flags_t flags_i,
  output oaht_pkg::ctl_t       ctl_o
);

  oaht_pkg::pc_e pc_q, pc_d;
  logic          take;

  // step counter, starts with the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= oaht_pkg::PC_CLR;
    end else begin
      pc_q <= pc_d;
    end
  end

  // control word fetch and jump decision
  always_comb begin
    ctl_o = oaht_pkg::rom(pc_q);
    case (ctl_o.cond)
      oaht_pkg::C_ALWAYS:    take = 1'b1;
      oaht_pkg::C_IN_FIRE:   take = flags_i.in_fire;
      oaht_pkg::C_CLR_LAST:  take = flags_i.clr_last;
      oaht_pkg::C_PROBE_END: take = flags_i.probe_end;
      oaht_pkg::C_OUT_FREE:  take = flags_i.out_free;
      default:               take = 1'b1;
    endcase
    pc_d = take ? ctl_o.target : pc_q;
  end

endmodule

`default_nettype wire

// File: hw/rtl/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: item registers, shared remainder unit, probe index arithmetic,
// slot memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire oaht_pkg::ctl_t   ctl_i,
  output oaht_pkg::flags_t      flags_o,
  input  wire logic             in_valid_i,
  input  wire oaht_pkg::in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output oaht_pkg::out_t        out_data_o,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_data_i
);

  // item registers
  oaht_pkg::func_e                    func_q;
  logic [oaht_pkg::KEY_W-1:0]         key_q;
  logic [oaht_pkg::VAL_W-1:0]         value_q;
  oaht_pkg::mode_e                    mode_q;

  // remainder unit
  logic [oaht_pkg::PROD_W-1:0]        prod_q;
  logic [oaht_pkg::REM_W-1:0]         rem_q;
  logic [31:0]                        recip;
  logic [oaht_pkg::KEY_W-1:0]         quot;
  logic [oaht_pkg::KEY_W-1:0]         qd;
  logic [oaht_pkg::REM_W-1:0]         div_val;
  logic [oaht_pkg::REM_W-1:0]         rem_fix;

  // probe state
  logic [oaht_pkg::IDX_W-1:0]         home_q;
  logic [oaht_pkg::IDX_W-1:0]         idx_q;
  logic [oaht_pkg::STEP_W-1:0]        step_q;
  logic [oaht_pkg::PROBE_W-1:0]       count_q, count_d;
  oaht_pkg::status_e                  status_q;
  logic [oaht_pkg::IDX_W:0]           idx_sum;
  logic [oaht_pkg::IDX_W-1:0]         idx_adv;
  logic                               wrap;

  // slot memory
  logic [oaht_pkg::IDX_W-1:0]         clr_cnt_q;
  logic                               ram_we, ram_re;
  logic [oaht_pkg::IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [oaht_pkg::ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic                               slot_valid;
  logic [oaht_pkg::KEY_W-1:0]         slot_key;
  logic                               empty, match, finish;

  // result register
  logic                               out_valid_q, out_valid_d;
  oaht_pkg::out_t                     out_q;
  logic                               out_free, out_load;

  // probe mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= oaht_pkg::MODE_LINEAR;
    end else if (cfg_valid_i) begin
      mode_q <= oaht_pkg::mode_e'(cfg_data_i);
    end
  end

  // input transaction capture
  always_ff @(posedge clk_i) begin
    if (flags_o.in_fire) begin
      func_q  <= in_data_i.func;
      key_q   <= in_data_i.key;
      value_q <= in_data_i.value;
    end
  end

  // remainder: quotient estimate by reciprocal, then one correction
  always_comb begin
    recip   = (ctl_i.mul_sel == oaht_pkg::DIV_TABLE) ? oaht_pkg::TAB_RECIP
                                                    : oaht_pkg::DH_RECIP;
    if (ctl_i.rem_sel == oaht_pkg::DIV_TABLE) begin
      quot    = oaht_pkg::KEY_W'(prod_q >> oaht_pkg::TAB_SHIFT);
      qd      = oaht_pkg::KEY_W'(quot * oaht_pkg::KEY_W'(oaht_pkg::TABLE_SIZE));
      div_val = oaht_pkg::REM_W'(oaht_pkg::TABLE_SIZE);
    end else begin
      quot    = oaht_pkg::KEY_W'(prod_q >> oaht_pkg::DH_SHIFT);
      qd      = oaht_pkg::KEY_W'(quot * oaht_pkg::KEY_W'(oaht_pkg::DH_PRIME));
      div_val = oaht_pkg::REM_W'(oaht_pkg::DH_PRIME);
    end
    rem_fix = (rem_q >= div_val) ? rem_q - div_val : rem_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= oaht_pkg::PROD_W'(key_q) * oaht_pkg::PROD_W'(recip);
    end
    if (ctl_i.rem_en) begin
      rem_q <= oaht_pkg::REM_W'(key_q - qd);
    end
  end

  // next probe index, wraps at the table size
  always_comb begin
    idx_sum = {1'b0, idx_q} + (oaht_pkg::IDX_W + 1)'(step_q);
    if (idx_sum >= (oaht_pkg::IDX_W + 1)'(oaht_pkg::TABLE_SIZE)) begin
      idx_adv = oaht_pkg::IDX_W'(idx_sum - (oaht_pkg::IDX_W + 1)'(oaht_pkg::TABLE_SIZE));
    end else begin
      idx_adv = idx_sum[oaht_pkg::IDX_W-1:0];
    end
    wrap = (idx_adv == home_q);
  end

  // slot examination
  always_comb begin
    slot_valid = ram_rdata[oaht_pkg::ENTRY_W-1];
    slot_key   = ram_rdata[oaht_pkg::VAL_W +: oaht_pkg::KEY_W];
    empty      = !slot_valid;
    match      = slot_valid && (slot_key == key_q);
    finish     = empty || match || wrap;
    count_d    = (count_q == oaht_pkg::PROBES_MAX) ? count_q : count_q + 1'b1;
  end

  // probe state registers
  always_ff @(posedge clk_i) begin
    if (flags_o.in_fire) begin
      count_q <= '0;
    end else if (ctl_i.eval) begin
      count_q <= count_d;
    end
    if (ctl_i.set_home) begin
      home_q <= oaht_pkg::IDX_W'(rem_fix);
      idx_q  <= oaht_pkg::IDX_W'(rem_fix);
    end else if (ctl_i.eval && !finish) begin
      idx_q <= idx_adv;
    end
    if (ctl_i.set_step) begin
      step_q <= (mode_q == oaht_pkg::MODE_DOUBLE)
              ? oaht_pkg::STEP_W'(oaht_pkg::DH_PRIME) - oaht_pkg::STEP_W'(rem_fix)
              : oaht_pkg::STEP_W'(1);
    end
    if (ctl_i.eval) begin
      if (empty) begin
        status_q <= (func_q == oaht_pkg::FUNC_INSERT) ? oaht_pkg::ST_INSERTED
                                                      : oaht_pkg::ST_NOT_FOUND;
      end else if (match) begin
        status_q <= (func_q == oaht_pkg::FUNC_INSERT) ? oaht_pkg::ST_UPDATED
                                                      : oaht_pkg::ST_FOUND;
      end else begin
        status_q <= (func_q == oaht_pkg::FUNC_INSERT) ? oaht_pkg::ST_FULL
                                                      : oaht_pkg::ST_NOT_FOUND;
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // memory port control
  always_comb begin
    ram_we    = ctl_i.clr_wr
             || (ctl_i.eval && (func_q == oaht_pkg::FUNC_INSERT) && (empty || match));
    ram_waddr = ctl_i.clr_wr ? clr_cnt_q : idx_q;
    ram_wdata = ctl_i.clr_wr ? '0 : {1'b1, key_q, value_q};
    ram_re    = ctl_i.rd_home || (ctl_i.eval && !finish);
    ram_raddr = ctl_i.rd_home ? idx_q : idx_adv;
  end

  oaht_ram #(
    .WIDTH (oaht_pkg::ENTRY_W),
    .DEPTH (oaht_pkg::TABLE_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    out_load    = ctl_i.out_load && out_free;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status <= status_q;
      out_q.probes <= count_q;
    end
  end

  // status back to the sequencer
  always_comb begin
    flags_o.in_fire   = in_valid_i && ctl_i.in_rdy;
    flags_o.clr_last  = (clr_cnt_q == oaht_pkg::IDX_W'(oaht_pkg::TABLE_SIZE - 1));
    flags_o.probe_end = finish;
    flags_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/open_addressing_hash_table.sv
// Flow: after an input transaction the sequencer forms the home slot and the step, runs
// the probe loop, which examines one slot a cycle through the registered read port of the
// slot memory, then loads the result; the next operation is taken only after that load.
// Reset: clears the probe mode to linear and starts a clearing pass that invalidates
// every slot; no input transaction is taken until it ends.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open addressing key/value table with linear or double hash probing, run by
// a microprogrammed sequencer over a single slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire oaht_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output oaht_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic           cfg_data_i
);

  oaht_pkg::ctl_t   ctl;
  oaht_pkg::flags_t flags;

  // sequencer
  oaht_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  // datapath
  oaht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .flags_o     (flags),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

  // handshakes
  assign in_ready_o  = ctl.in_rdy;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// File: test/open_addressing_hash_table_tb.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Self-checking bench for the open addressing hash table. A shadow copy of
// the slot table predicts status and probe count for every accepted
// transaction, in both probe modes, from an empty table up to a full one.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int unsigned HOT_N        = 8;
  // largest multiplier of the table size that keeps a key within 31 bits
  localparam int unsigned MULT_MAX     = 2103313;
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned SHOW_MAX     = 10;

  typedef struct {
    in_t  op;
    out_t answer;
  } due_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i  = 1'b0;

  // shadow of the slot table and the probe mode
  logic             shadow_used [TABLE_SIZE] = '{default: 1'b0};
  logic [KEY_W-1:0] shadow_key  [TABLE_SIZE];
  mode_e            shadow_mode = MODE_LINEAR;

  in_t              ops_to_send [$];
  due_t             answers_due [$];
  logic [KEY_W-1:0] issued_keys [$];
  int unsigned      hot_base [HOT_N];

  bit          no_gaps         = 1'b0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned ops_sent        = 0;
  int unsigned mode_writes     = 0;
  int unsigned status_seen [5] = '{default: 0};

  open_addressing_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // run one operation against the shadow table and return its answer
  function automatic out_t shadow_apply(in_t op);
    int unsigned home;
    int unsigned stride;
    int unsigned slot;
    int unsigned count;
    status_e     st;
    bit          done;
    home   = op.key % TABLE_SIZE;
    stride = (shadow_mode == MODE_LINEAR) ? 1 : (DH_PRIME - op.key % DH_PRIME) % TABLE_SIZE;
    slot   = home;
    count  = 0;
    done   = 1'b0;
    st     = ST_NOT_FOUND;
    while (!done) begin
      count++;
      if (!shadow_used[slot]) begin
        if (op.func == FUNC_INSERT) begin
          shadow_used[slot] = 1'b1;
          shadow_key[slot]  = op.key;
          st = ST_INSERTED;
        end else begin
          st = ST_NOT_FOUND;
        end
        done = 1'b1;
      end else if (shadow_key[slot] == op.key) begin
        st   = (op.func == FUNC_INSERT) ? ST_UPDATED : ST_FOUND;
        done = 1'b1;
      end else begin
        slot = (slot + stride) % TABLE_SIZE;
        // back at home: every slot of the probe cycle was taken
        if (slot == home) begin
          st   = (op.func == FUNC_INSERT) ? ST_FULL : ST_NOT_FOUND;
          done = 1'b1;
        end
      end
    end
    if (count > PROBES_MAX) count = PROBES_MAX;
    return '{status: st, probes: PROBE_W'(count)};
  endfunction

  // driver: predict on each accepted transaction, then present the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        due_t d;
        d.op     = in_data_i;
        d.answer = shadow_apply(in_data_i);
        status_seen[int'(d.answer.status)]++;
        answers_due.push_back(d);
        ops_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0 || ops_to_send.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= ops_to_send.pop_front();
          send_gap   = pick_gap();
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("%0t: unexpected result status %0d probes %0d", $realtime,
                     out_data_o.status, out_data_o.probes);
        end else begin
          due_t d;
          d = answers_due.pop_front();
          results_checked++;
          if (out_data_o.status !== d.answer.status ||
              out_data_o.probes !== d.answer.probes) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display("%0t: func %0d key %h: status exp %0d got %0d, probes exp %0d got %0d",
                       $realtime, d.op.func, d.op.key, d.answer.status, out_data_o.status,
                       d.answer.probes, out_data_o.probes);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic push_op(func_e f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    ops_to_send.push_back(in_t'{f, k, v});
  endtask

  // block idle: nothing left to send and no result outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ops_to_send.size() != 0 || in_valid_i || answers_due.size() != 0);
  endtask

  task automatic write_mode(mode_e m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    shadow_mode = m;
    mode_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // clustered homes give long chains, the rest are random over all key bits or near the top key
  function automatic logic [KEY_W-1:0] fresh_key();
    int unsigned r;
    int unsigned home;
    r = $urandom_range(3);
    if (r < 2) begin
      home = (hot_base[$urandom_range(HOT_N-1)] + $urandom_range(15)) % TABLE_SIZE;
      return KEY_W'(home + TABLE_SIZE * $urandom_range(MULT_MAX));
    end
    if (r == 2) return KEY_W'($urandom);
    return KEY_W'({KEY_W{1'b1}} - $urandom_range(4095));
  endfunction

  function automatic bit key_stored(logic [KEY_W-1:0] k);
    for (int unsigned s = 0; s < TABLE_SIZE; s++)
      if (shadow_used[s] && shadow_key[s] == k) return 1'b1;
    return 1'b0;
  endfunction

  // inserts of new keys, updates and lookups of known keys, lookups of fresh keys
  task automatic queue_random_ops(int unsigned n);
    int unsigned      r;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40 || issued_keys.size() == 0) begin
        k = fresh_key();
        issued_keys.push_back(k);
        push_op(FUNC_INSERT, k, $urandom);
      end else if (r < 55) begin
        push_op(FUNC_INSERT, issued_keys[$urandom_range(issued_keys.size()-1)], $urandom);
      end else if (r < 80) begin
        push_op(FUNC_LOOKUP, issued_keys[$urandom_range(issued_keys.size()-1)], $urandom);
      end else begin
        push_op(FUNC_LOOKUP, fresh_key(), $urandom);
      end
    end
  endtask

  // one insert per empty slot, each key homed on that slot
  task automatic fill_empty_slots();
    for (int unsigned s = 0; s < TABLE_SIZE; s++)
      if (!shadow_used[s])
        push_op(FUNC_INSERT, KEY_W'(s + TABLE_SIZE * $urandom_range(MULT_MAX)), $urandom);
  endtask

  // full table: absent keys wrap around the whole probe cycle
  task automatic queue_full_table_ops(int unsigned n);
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      sel = (i < 4) ? i : $urandom_range(3);
      if (sel < 2) begin
        do k = KEY_W'($urandom);
        while (key_stored(k));
        push_op((sel == 0) ? FUNC_INSERT : FUNC_LOOKUP, k, $urandom);
      end else begin
        k = shadow_key[$urandom_range(TABLE_SIZE-1)];
        push_op((sel == 2) ? FUNC_LOOKUP : FUNC_INSERT, k, $urandom);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    for (int unsigned h = 0; h < HOT_N; h++) hot_base[h] = $urandom_range(TABLE_SIZE-1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // linear probing: empty table, collisions, update, top key, wrap past last slot
    push_op(FUNC_LOOKUP, 0, '1);
    push_op(FUNC_INSERT, 0, 0);
    push_op(FUNC_INSERT, TABLE_SIZE, '1);
    push_op(FUNC_INSERT, 2 * TABLE_SIZE, 32'h5a5a_a5a5);
    push_op(FUNC_LOOKUP, 2 * TABLE_SIZE, 0);
    push_op(FUNC_INSERT, TABLE_SIZE, 32'h1234_5678);
    push_op(FUNC_LOOKUP, 3 * TABLE_SIZE, '1);
    push_op(FUNC_INSERT, '1, '1);
    push_op(FUNC_LOOKUP, '1, 0);
    push_op(FUNC_INSERT, TABLE_SIZE - 1, 1);
    push_op(FUNC_INSERT, 2 * TABLE_SIZE - 1, 2);
    push_op(FUNC_LOOKUP, 2 * TABLE_SIZE - 1, 0);
    wait_drained();

    // double hashing: largest and smallest step, keys placed by the other mode
    write_mode(MODE_DOUBLE);
    push_op(FUNC_INSERT, DH_PRIME * TABLE_SIZE, 3);
    push_op(FUNC_INSERT, 16 * TABLE_SIZE, 4);
    push_op(FUNC_LOOKUP, DH_PRIME * TABLE_SIZE, 0);
    push_op(FUNC_LOOKUP, 0, 0);
    push_op(FUNC_LOOKUP, TABLE_SIZE, 0);
    push_op(FUNC_INSERT, '1, 0);
    wait_drained();

    // random phases, alternating modes, one without any idling
    write_mode(MODE_LINEAR);
    queue_random_ops(100);
    wait_drained();
    write_mode(MODE_DOUBLE);
    queue_random_ops(100);
    wait_drained();
    no_gaps = 1'b1;
    write_mode(MODE_LINEAR);
    queue_random_ops(40);
    wait_drained();
    no_gaps = 1'b0;
    write_mode(MODE_DOUBLE);
    queue_random_ops(60);
    wait_drained();

    // fill every slot, then work on the full table in both modes
    write_mode(MODE_LINEAR);
    fill_empty_slots();
    wait_drained();
    queue_full_table_ops(8);
    wait_drained();
    write_mode(MODE_DOUBLE);
    queue_full_table_ops(8);
    wait_drained();
    write_mode(MODE_LINEAR);
    queue_full_table_ops(4);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += answers_due.size();
    $display("%0d operations over %0d probe mode writes, %0d results checked",
             ops_sent, mode_writes, results_checked);
    $display("outcomes: %0d inserted, %0d updated, %0d full, %0d found, %0d not found",
             status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FULL],
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: open_addressing_hash_table.f
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_useq.sv
hw/rtl/oaht_dp.sv
hw/rtl/open_addressing_hash_table.sv
test/open_addressing_hash_table_tb.sv
